[sv/bmhq_pkg.sv]
// Shared types and constants of the binary max-heap priority queue.
// Used by the channel interfaces, the cell and the top level.
package bmhq_pkg;

   // Field widths of the channels
   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;

   // Widest key the design supports, and parameter defaults
   localparam int KEY_MAX_W         = 64;
   localparam int STORE_DEPTH_DEF   = 64;
   localparam int KEY_WIDTH_DEF     = 32;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OPC_PUSH = 2'd0;
   localparam logic [OPCODE_W-1:0] OPC_POP  = 2'd1;
   localparam logic [OPCODE_W-1:0] OPC_PEEK = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        in_use;   // cell holds one of the live keys
   } cell_ctl_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  top_value;
      logic                top_valid;
      logic [COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

endpackage

[sv/bmhq_req_if.sv]
// Request channel of the priority queue: valid/ready plus opcode and value.
// Depends on bmhq_pkg for the field widths.
interface bmhq_req_if;
   logic                          valid;
   logic                          ready;
   logic [bmhq_pkg::OPCODE_W-1:0] opcode;
   logic [bmhq_pkg::VALUE_W-1:0]  value;

   modport source (output valid, opcode, value, input ready);
   modport sink   (input valid, opcode, value, output ready);
endinterface

[sv/bmhq_rsp_if.sv]
// Response channel of the priority queue: valid/ready plus result fields.
// Depends on bmhq_pkg for the field widths.
interface bmhq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmhq_pkg::VALUE_W-1:0]  top_value;
   logic                          top_valid;
   logic [bmhq_pkg::COUNT_W-1:0]  entry_count;
   logic [bmhq_pkg::STATUS_W-1:0] status;

   modport source (output valid, top_value, top_valid, entry_count, status, input ready);
   modport sink   (input valid, top_value, top_valid, entry_count, status, output ready);
endinterface

[sv/bmhq_cell.sv]
// One slot of the sorted key chain. Holds one key, compares it with the
// broadcast push key and shifts toward its neighbors. Depends on bmhq_pkg.
module bmhq_cell #(
   parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
   input  logic                 clock,
   input  bmhq_pkg::cell_ctl_type ctl,
   input  logic [KEY_WIDTH-1:0] new_key,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic                 left_keep,
   input  logic [KEY_WIDTH-1:0] right_key,
   output logic [KEY_WIDTH-1:0] key,
   output logic [KEY_WIDTH-1:0] next_key,
   output logic                 keep
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // live keys are sorted descending, so keep is a prefix of the chain
   assign keep = ctl.in_use && (key_ff >= new_key);

   always_comb begin
      case (ctl.op)
         bmhq_pkg::CELL_PUSH: begin
            if (keep) begin
               key_in = key_ff;
            end else if (left_keep) begin
               key_in = new_key;
            end else begin
               key_in = left_key;
            end
         end
         bmhq_pkg::CELL_POP: begin
            key_in = right_key;
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key      = key_ff;
   assign next_key = key_in;

endmodule

[sv/binary_max_heap_queue_top.sv]
// Priority queue holding up to STORE_DEPTH-1 keys, returning the maximum.
// Usage:
//   req_ch carries one item per operation: opcode 0 pushes value, 1 pops
//   the largest key, 2 (and 3) only peeks. rsp_ch returns exactly one item
//   per request: the largest key after the operation (zero when empty),
//   a non-empty flag, the key count and a status (0 ok, 1 push rejected
//   because full, 2 pop rejected because empty). Rejected operations leave
//   the contents unchanged.
// Timing:
//   Keys live in a chain of STORE_DEPTH-1 cells kept in descending order.
//   Every cell compares itself with the pushed key and, where needed, shifts
//   one place in the same cycle, whatever the fill: the response is registered
//   and valid in the cycle after acceptance, and a new request is taken every
//   cycle while the receiver does not stall.
//   The response sits in an output register; while the receiver stalls,
//   req_ch.ready drops and the register holds its item.
// Reset:
//   Synchronous, active high. Empties the queue and drops the pending
//   response; req_ch.ready is low while reset is high.
// Depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and bmhq_cell.
module binary_max_heap_queue_top #(
   parameter int STORE_DEPTH = bmhq_pkg::STORE_DEPTH_DEF,
   parameter int KEY_WIDTH   = bmhq_pkg::KEY_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   bmhq_req_if.sink   req_ch,
   bmhq_rsp_if.source rsp_ch
);

   localparam int NUM_CELLS = STORE_DEPTH - 1;
   localparam int CNT_W     = $clog2(STORE_DEPTH);
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(NUM_CELLS);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   bmhq_pkg::rsp_payload_type rsp_ff;
   bmhq_pkg::rsp_payload_type rsp_in;

   logic                          accept;
   bmhq_pkg::cell_op_type         op;
   logic [bmhq_pkg::STATUS_W-1:0] status;
   logic [bmhq_pkg::KEY_MAX_W-1:0] value_ext;
   logic [KEY_WIDTH-1:0]           new_key;
   logic [bmhq_pkg::KEY_MAX_W-1:0] top_ext;
   logic [31:0]                    count_ext;

   logic [KEY_WIDTH-1:0] cell_key  [NUM_CELLS];
   logic [KEY_WIDTH-1:0] cell_next [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_keep;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign value_ext = bmhq_pkg::KEY_MAX_W'(req_ch.value);
   assign new_key   = value_ext[KEY_WIDTH-1:0];

   // decode the request against the current fill
   always_comb begin
      op       = bmhq_pkg::CELL_HOLD;
      status   = bmhq_pkg::ST_OK;
      count_in = count_ff;
      if (accept) begin
         case (req_ch.opcode)
            bmhq_pkg::OPC_PUSH: begin
               if (count_ff >= CAPACITY) begin
                  status = bmhq_pkg::ST_FULL;
               end else begin
                  op       = bmhq_pkg::CELL_PUSH;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            bmhq_pkg::OPC_POP: begin
               if (count_ff == '0) begin
                  status = bmhq_pkg::ST_EMPTY;
               end else begin
                  op       = bmhq_pkg::CELL_POP;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               op = bmhq_pkg::CELL_HOLD;
            end
         endcase
      end
   end

   genvar i;
   generate
      for (i = 0; i < NUM_CELLS; i++) begin : g_cell
         bmhq_pkg::cell_ctl_type ctl;
         logic [KEY_WIDTH-1:0]   left_key;
         logic                   left_keep;
         logic [KEY_WIDTH-1:0]   right_key;

         assign ctl = '{op: op, in_use: (CNT_W'(i) < count_ff)};

         if (i == 0) begin : g_head
            assign left_key  = new_key;
            assign left_keep = 1'b1;
         end else begin : g_body
            assign left_key  = cell_key[i-1];
            assign left_keep = cell_keep[i-1];
         end

         if (i == NUM_CELLS - 1) begin : g_tail
            assign right_key = cell_key[i];
         end else begin : g_mid
            assign right_key = cell_key[i+1];
         end

         bmhq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .new_key   (new_key),
            .left_key  (left_key),
            .left_keep (left_keep),
            .right_key (right_key),
            .key       (cell_key[i]),
            .next_key  (cell_next[i]),
            .keep      (cell_keep[i])
         );
      end
   endgenerate

   assign top_ext   = bmhq_pkg::KEY_MAX_W'(cell_next[0]);
   assign count_ext = 32'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.top_valid   = (count_in != '0);
         rsp_in.top_value   = (count_in != '0) ? top_ext[bmhq_pkg::VALUE_W-1:0] : '0;
         rsp_in.entry_count = count_ext[bmhq_pkg::COUNT_W-1:0];
         rsp_in.status      = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.top_value   = rsp_ff.top_value;
   assign rsp_ch.top_valid   = rsp_ff.top_valid;
   assign rsp_ch.entry_count = rsp_ff.entry_count;
   assign rsp_ch.status      = rsp_ff.status;

   // every accepted item yields a pending response
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no response");

   // a pending response describes the current fill
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.top_valid == (count_ff != '0)))
      else $error("response non-empty flag disagrees with fill");

   // rejected push leaves the fill unchanged
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.opcode == bmhq_pkg::OPC_PUSH && count_ff == CAPACITY)
      |=> $stable(count_ff))
      else $error("rejected push changed the fill");

   // the head of the chain is the maximum
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_key[0] >= cell_key[1]))
      else $error("key chain out of order at head");

endmodule
